// ----- src/random_rare_event_trigger_core_macros.svh -----
// Assertion helpers shared by the trigger core.
// Each one samples on clk and is disabled while rst_n is low.
`ifndef RANDOM_RARE_EVENT_TRIGGER_CORE_MACROS_SVH
`define RANDOM_RARE_EVENT_TRIGGER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRET_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RRET_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/rret_pkg.sv -----
`timescale 1ns / 1ps
package rret_pkg;

  localparam int CHANNELS   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int RATE_W     = 40;

  // Opcodes of an input item
  localparam logic [1:0] OP_FIRST   = 2'd0;
  localparam logic [1:0] OP_SECOND  = 2'd1;
  localparam logic [1:0] OP_THIRD   = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESTART_SEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_RATE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_RATE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THIRD_RATE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP_MS   = 3'd4;

  // Generator constants
  localparam logic [31:0] SEED_DEFAULT = 32'h9E37_79B9;
  localparam int XS_SHIFT_A = 13;
  localparam int XS_SHIFT_B = 17;
  localparam int XS_SHIFT_C = 5;
  localparam int ROLL_DROP  = 8;
  localparam int ROLL_SCALE = 24;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] elapsed_ms;
    logic        condition;
    logic [47:0] time_now_ms;
  } item_t;

  typedef struct packed {
    logic        fired;
    logic [15:0] event_count;
  } res_t;

  typedef struct packed {
    logic [31:0]       restart_seed;
    logic [RATE_W-1:0] first_rate;
    logic [RATE_W-1:0] second_rate;
    logic [RATE_W-1:0] third_rate;
    logic [31:0]       min_gap_ms;
  } cfg_t;

  typedef struct packed {
    logic [31:0]                rng_word;
    logic [47:0]                last_fire_time;
    logic                       has_fired_before;
    logic                       prev_cond_second;
    logic                       armed_second;
    logic                       prev_cond_third;
    logic                       armed_third;
    logic [CHANNELS-1:0][15:0]  fire_counts;
  } state_t;

endpackage

// ----- src/rret_ifs.sv -----
`timescale 1ns / 1ps
// Tick channel into the core
interface rret_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] elapsed_ms;
  logic        condition;
  logic [47:0] time_now_ms;

  modport source (output valid, opcode, elapsed_ms, condition, time_now_ms, input ready);
  modport sink   (input valid, opcode, elapsed_ms, condition, time_now_ms, output ready);
endinterface

// Result channel out of the core
interface rret_out_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [15:0] event_count;

  modport source (output valid, fired, event_count, input ready);
  modport sink   (input valid, fired, event_count, output ready);
endinterface

// ----- src/random_rare_event_trigger_core.sv -----
// Random rare-event trigger for three channels sharing one xorshift32 generator.
// in_ch carries ticks: opcode 0..2 ticks that channel, opcode 3 restarts
// (reseed from the seed register, clear all channel state). Each accepted item
// gives exactly one result on out_ch: fired and the channel's 16-bit firing count.
// Configuration is written through cfg_we / cfg_idx / cfg_data, one register
// per cycle; the user must keep such writes to times when the block is idle,
// as the block itself does not enforce it. A new seed takes effect at restart.
// An accepted item is registered in the input register, evaluated, and its
// result loaded into the output register once that frees, raising out_ch.valid.
// Throughput is one item per cycle while the receiver takes results: the
// generator step, the 16x40 roll multiply and the compares sit in one stage
// between the two registers, and the channel state updates in that same cycle.
// When the receiver stalls, the output register holds its result and the
// input register holds one more item; in_ch.ready drops only when both are
// full. Reset (rst_n low, synchronous) empties both stages, loads the
// default seed and rates of zero, and clears all channel state.
`timescale 1ns / 1ps
`include "random_rare_event_trigger_core_macros.svh"
module random_rare_event_trigger_core import rret_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  rret_in_if.sink               in_ch,
  rret_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg_r;
  state_t st_r;
  state_t st_nxt;
  state_t st_rst;
  item_t  s1_item_r;
  logic   s1_v_r;
  res_t   out_res_r;
  logic   out_v_r;
  res_t   res;
  logic   adv;
  logic   load;
  logic   in_xfer;

  // Handshake: the result register frees when empty or taken
  assign adv          = !out_v_r || out_ch.ready;
  assign in_ch.ready  = !s1_v_r || adv;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign load         = s1_v_r && adv;
  assign out_ch.valid = out_v_r;
  assign out_ch.fired       = out_res_r.fired;
  assign out_ch.event_count = out_res_r.event_count;

  rret_eval u_eval (
    .item   (s1_item_r),
    .st     (st_r),
    .cfg    (cfg_r),
    .st_nxt (st_nxt),
    .res    (res)
  );

  // Reset value of the channel state: default seed, all else clear
  always_comb begin
    st_rst          = '0;
    st_rst.rng_word = SEED_DEFAULT;
  end

  // Configuration registers; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.restart_seed <= SEED_DEFAULT;
      cfg_r.first_rate   <= '0;
      cfg_r.second_rate  <= '0;
      cfg_r.third_rate   <= '0;
      cfg_r.min_gap_ms   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_RESTART_SEED: cfg_r.restart_seed <= cfg_data[31:0];
        REG_FIRST_RATE:   cfg_r.first_rate   <= cfg_data[RATE_W-1:0];
        REG_SECOND_RATE:  cfg_r.second_rate  <= cfg_data[RATE_W-1:0];
        REG_THIRD_RATE:   cfg_r.third_rate   <= cfg_data[RATE_W-1:0];
        REG_MIN_GAP_MS:   cfg_r.min_gap_ms   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Stage valids and channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      st_r    <= st_rst;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
      if (load) begin
        st_r <= st_nxt;
      end
    end
  end

  // Payload registers: capture on transfer, hold under stall
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r.opcode      <= in_ch.opcode;
      s1_item_r.elapsed_ms  <= in_ch.elapsed_ms;
      s1_item_r.condition   <= in_ch.condition;
      s1_item_r.time_now_ms <= in_ch.time_now_ms;
    end
    if (load) begin
      out_res_r <= res;
    end
  end

  `RRET_ASSERT_IMP(a_ready_when_empty, !out_v_r, in_ch.ready, "input stalled with empty output")
  `RRET_ASSERT_IMP(a_rng_nonzero, 1'b1, st_r.rng_word != '0, "generator word reached zero")
  `RRET_ASSERT_NXT(a_restart_clears, load && (s1_item_r.opcode == OP_RESTART),
    !out_res_r.fired && (out_res_r.event_count == '0) && !st_r.armed_second,
    "restart left state or result nonzero")
  `RRET_ASSERT_NXT(a_first_fire_time, load && res.fired && (s1_item_r.opcode == OP_FIRST),
    st_r.has_fired_before && (st_r.last_fire_time == $past(s1_item_r.time_now_ms)),
    "first channel firing did not record its time")
  `RRET_ASSERT_NXT(a_second_disarm, load && res.fired && (s1_item_r.opcode == OP_SECOND),
    !st_r.armed_second, "second channel stayed armed after firing")

endmodule

// ----- src/rret_eval.sv -----
`timescale 1ns / 1ps
module rret_eval import rret_pkg::*; (
  input  item_t  item,
  input  state_t st,
  input  cfg_t   cfg,
  output state_t st_nxt,
  output res_t   res
);

  typedef struct packed {
    logic prev;
    logic armed;
    logic roll;
  } sess_t;

  // Session channel: re-arm on a low condition or a fresh rise, roll while armed
  function automatic sess_t session_step(input logic cond, input logic prev,
                                         input logic armed);
    sess_t s;
    s.prev  = cond;
    s.armed = !cond || armed || !prev;
    s.roll  = cond && (armed || !prev);
    return s;
  endfunction

  logic [31:0]       xs_a;
  logic [31:0]       xs_b;
  logic [31:0]       xs_c;
  logic [RATE_W-1:0] rate;
  logic [55:0]       prod;
  logic [47:0]       lhs;
  logic              success;
  logic [47:0]       gap;
  logic              blocked;
  logic              rolled;
  logic              fired;
  sess_t             sess;

  // Next generator word
  assign xs_a = st.rng_word ^ (st.rng_word << XS_SHIFT_A);
  assign xs_b = xs_a ^ (xs_a >> XS_SHIFT_B);
  assign xs_c = xs_b ^ (xs_b << XS_SHIFT_C);

  // Pick the rate of the ticked channel
  always_comb begin
    unique case (item.opcode)
      OP_FIRST:   rate = cfg.first_rate;
      OP_SECOND:  rate = cfg.second_rate;
      OP_THIRD:   rate = cfg.third_rate;
      default:    rate = '0;
    endcase
  end

  // Poisson roll: top 24 random bits scaled by 2^24 against elapsed times rate
  assign prod    = item.elapsed_ms * rate;
  assign lhs     = {xs_c[31:ROLL_DROP], {ROLL_SCALE{1'b0}}};
  assign success = {8'b0, lhs} < prod;

  // Minimum interval check for the first channel, modulo 2^48
  assign gap     = item.time_now_ms - st.last_fire_time;
  assign blocked = st.has_fired_before && (gap < {16'b0, cfg.min_gap_ms});

  always_comb begin
    st_nxt = st;
    rolled = 1'b0;
    fired  = 1'b0;
    sess   = '0;
    res    = '0;
    unique case (item.opcode)
      OP_FIRST: begin
        rolled = item.condition && !blocked;
        if (rolled && success) begin
          fired                  = 1'b1;
          st_nxt.last_fire_time   = item.time_now_ms;
          st_nxt.has_fired_before = 1'b1;
        end
      end
      OP_SECOND: begin
        sess   = session_step(item.condition, st.prev_cond_second, st.armed_second);
        rolled = sess.roll;
        fired  = sess.roll && success;
        st_nxt.prev_cond_second = sess.prev;
        st_nxt.armed_second     = sess.armed && !fired;
      end
      OP_THIRD: begin
        sess   = session_step(item.condition, st.prev_cond_third, st.armed_third);
        rolled = sess.roll;
        fired  = sess.roll && success;
        st_nxt.prev_cond_third = sess.prev;
        st_nxt.armed_third     = sess.armed && !fired;
      end
      default: begin
        // Restart: reseed and clear everything else
        st_nxt          = '0;
        st_nxt.rng_word = (cfg.restart_seed != '0) ? cfg.restart_seed : SEED_DEFAULT;
      end
    endcase

    // Advance the generator only when a roll was made
    if (rolled) begin
      st_nxt.rng_word = xs_c;
    end

    // Bump and report the ticked channel's counter
    if (item.opcode != OP_RESTART) begin
      if (fired) begin
        st_nxt.fire_counts[item.opcode] = st.fire_counts[item.opcode] + 16'd1;
      end
      res.fired       = fired;
      res.event_count = st_nxt.fire_counts[item.opcode];
    end
  end

endmodule

// ----- verif/tb_random_rare_event_trigger_core.sv -----
`timescale 1ns / 1ps
module tb_random_rare_event_trigger_core;
  import rret_pkg::*;

  localparam int unsigned LIMIT_CYCLES  = 400000;
  localparam int          SETTLE_CYCLES = 8;
  localparam logic [15:0] MAX_MS        = 16'hFFFF;
  localparam logic [47:0] TOP_MS        = 48'hFFFF_FFFF_FFFF;
  localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_t;

  // Mirror of the trigger: registers, generator, channel state and the
  // results still owed by the block.
  class trigger_tracker;
    logic [31:0]       seed_reg;
    logic [RATE_W-1:0] rate_reg [CHANNELS];
    logic [31:0]       gap_reg;
    logic [31:0]       xs_word;
    logic [47:0]       last_fire_ms;
    bit                fired_once;
    bit                cond_seen [CHANNELS];
    bit                armed [CHANNELS];
    logic [15:0]       fire_count [CHANNELS];
    res_t              pending_fires [$];
    int unsigned       errors;

    function void reseed_and_clear();
      xs_word      = (seed_reg != '0) ? seed_reg : SEED_DEFAULT;
      last_fire_ms = '0;
      fired_once   = 1'b0;
      foreach (fire_count[i]) begin
        cond_seen[i]  = 1'b0;
        armed[i]      = 1'b0;
        fire_count[i] = '0;
      end
    endfunction

    function void power_on();
      seed_reg = SEED_DEFAULT;
      foreach (rate_reg[i]) rate_reg[i] = '0;
      gap_reg = '0;
      errors  = 0;
      reseed_and_clear();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RESTART_SEED: seed_reg            = data[31:0];
        REG_FIRST_RATE:   rate_reg[OP_FIRST]  = data[RATE_W-1:0];
        REG_SECOND_RATE:  rate_reg[OP_SECOND] = data[RATE_W-1:0];
        REG_THIRD_RATE:   rate_reg[OP_THIRD]  = data[RATE_W-1:0];
        REG_MIN_GAP_MS:   gap_reg             = data[31:0];
        default: ;
      endcase
    endfunction

    // Advance the xorshift word and compare the top 24 bits, scaled to 48,
    // against elapsed times rate.
    function bit poisson_roll(logic [15:0] elapsed, logic [RATE_W-1:0] rate);
      logic [31:0] x;
      logic [55:0] lhs;
      logic [55:0] rhs;
      x = xs_word;
      x = x ^ (x << XS_SHIFT_A);
      x = x ^ (x >> XS_SHIFT_B);
      x = x ^ (x << XS_SHIFT_C);
      xs_word = x;
      lhs = x[31:ROLL_DROP];
      lhs = lhs << ROLL_SCALE;
      rhs = elapsed * rate;
      return lhs < rhs;
    endfunction

    // Fire at most once per session of the condition.
    function bit session_tick(int ch, bit cond, logic [15:0] elapsed);
      if (!cond) begin
        cond_seen[ch] = 1'b0;
        armed[ch]     = 1'b1;
        return 1'b0;
      end
      if (!cond_seen[ch]) armed[ch] = 1'b1;
      cond_seen[ch] = 1'b1;
      if (!armed[ch]) return 1'b0;
      if (!poisson_roll(elapsed, rate_reg[ch])) return 1'b0;
      armed[ch] = 1'b0;
      return 1'b1;
    endfunction

    function void note_tick(item_t it);
      res_t        r;
      bit          hit;
      bit          blocked;
      logic [47:0] since_fire;
      hit = 1'b0;
      if (it.opcode == OP_RESTART) begin
        reseed_and_clear();
        r = '0;
      end else begin
        if (it.opcode == OP_FIRST) begin
          if (it.condition) begin
            since_fire = it.time_now_ms - last_fire_ms;
            blocked = fired_once && (since_fire < {16'd0, gap_reg});
            if (!blocked) begin
              if (poisson_roll(it.elapsed_ms, rate_reg[OP_FIRST])) begin
                last_fire_ms = it.time_now_ms;
                fired_once   = 1'b1;
                hit          = 1'b1;
              end
            end
          end
        end else begin
          hit = session_tick(int'(it.opcode), it.condition, it.elapsed_ms);
        end
        if (hit) fire_count[it.opcode] = fire_count[it.opcode] + 16'd1;
        r.fired       = hit;
        r.event_count = fire_count[it.opcode];
      end
      pending_fires.push_back(r);
    endfunction

    function void check_outcome(res_t got);
      res_t want;
      if (pending_fires.size() == 0) begin
        $error("result with nothing pending: fired %0d event_count %0d",
               got.fired, got.event_count);
        errors++;
        return;
      end
      want = pending_fires.pop_front();
      if (got.fired !== want.fired) begin
        $error("fired: expected %0d, actual %0d", want.fired, got.fired);
        errors++;
      end
      if (got.event_count !== want.event_count) begin
        $error("event_count: expected %0d, actual %0d", want.event_count, got.event_count);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  rret_in_if  in_ch ();
  rret_out_if out_ch ();

  trigger_tracker tracker;
  logic [47:0]    wall_ms;
  bit             session_cond [CHANNELS];
  int             burst_left;
  int unsigned    cycles;
  item_t          seen_tick;
  res_t           seen_res;

  random_rare_event_trigger_core u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("tb_random_rare_event_trigger_core: errors");
      $finish;
    end
  end

  // Predict on each input transfer, check on each result transfer
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        seen_tick.opcode      = in_ch.opcode;
        seen_tick.elapsed_ms  = in_ch.elapsed_ms;
        seen_tick.condition   = in_ch.condition;
        seen_tick.time_now_ms = in_ch.time_now_ms;
        tracker.note_tick(seen_tick);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_res.fired       = out_ch.fired;
        seen_res.event_count = out_ch.event_count;
        tracker.check_outcome(seen_res);
      end
    end
  end

  // Receiver: stall in modes of random length
  initial begin
    rx_mode_t mode;
    int       left;
    out_ch.ready = 1'b0;
    mode = RX_OPEN;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(4, 40);
      end
      left--;
      case (mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= (left % 3 == 0);
        default:   out_ch.ready <= 1'b0;
      endcase
    end
  end

  function automatic item_t make_tick(logic [1:0] op, logic [15:0] elapsed, bit cond,
                                      logic [47:0] now);
    item_t it;
    it.opcode      = op;
    it.elapsed_ms  = elapsed;
    it.condition   = cond;
    it.time_now_ms = now;
    return it;
  endfunction

  function automatic logic [47:0] any_time();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[47:0];
  endfunction

  // Random rate scaled down so that firing odds spread from near certain
  // to about one in a few thousand
  function automatic logic [RATE_W-1:0] any_rate();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[RATE_W-1:0] >> $urandom_range(1, 12);
  endfunction

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    tracker.write_reg(idx, data);
  endtask

  // Present one tick, hold it until the transfer, then maybe open a gap
  task automatic send_tick(item_t it);
    int gap;
    @(negedge clk);
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= it.opcode;
    in_ch.elapsed_ms  <= it.elapsed_ms;
    in_ch.condition   <= it.condition;
    in_ch.time_now_ms <= it.time_now_ms;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Drop valid and wait for every owed result plus the pipeline depth
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (tracker.pending_fires.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  // Load a full register set, restart, then stream random ticks
  task automatic run_phase(logic [31:0] seed, logic [RATE_W-1:0] rate_a,
                           logic [RATE_W-1:0] rate_b, logic [RATE_W-1:0] rate_c,
                           logic [31:0] gap, int n_ticks);
    item_t       it;
    int unsigned pick;
    int          ch;
    cfg_write(REG_RESTART_SEED, CFG_DATA_W'(seed));
    cfg_write(REG_FIRST_RATE, rate_a);
    cfg_write(REG_SECOND_RATE, rate_b);
    cfg_write(REG_THIRD_RATE, rate_c);
    cfg_write(REG_MIN_GAP_MS, CFG_DATA_W'(gap));
    send_tick(make_tick(OP_RESTART, 16'($urandom), 1'($urandom), any_time()));
    wall_ms = ($urandom_range(0, 3) == 0) ? TOP_MS - 48'($urandom_range(0, 5000))
                                          : any_time();
    repeat (n_ticks) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)       it.elapsed_ms = '0;
      else if (pick < 8)  it.elapsed_ms = MAX_MS;
      else if (pick < 18) it.elapsed_ms = 16'($urandom);
      else                it.elapsed_ms = 16'($urandom_range(1, 1500));
      // advance the clock, with an occasional jump anywhere in its range
      if ($urandom_range(0, 29) == 0) wall_ms = any_time();
      else                            wall_ms = wall_ms + 48'(it.elapsed_ms);
      it.time_now_ms = wall_ms;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        it.opcode    = OP_RESTART;
        it.condition = 1'($urandom);
      end else begin
        ch = $urandom_range(0, CHANNELS - 1);
        it.opcode = ch[1:0];
        if ($urandom_range(0, 5) == 0) session_cond[ch] = !session_cond[ch];
        it.condition = session_cond[ch];
      end
      send_tick(it);
    end
    settle();
  endtask

  initial begin
    tracker = new;
    tracker.power_on();
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_FIRST;
    in_ch.elapsed_ms  = '0;
    in_ch.condition   = 1'b0;
    in_ch.time_now_ms = '0;
    cycles            = 0;
    burst_left        = 0;
    wall_ms           = '0;
    foreach (session_cond[i]) session_cond[i] = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // indexes past the register list must leave everything alone
    for (int k = int'(REG_MIN_GAP_MS) + 1; k < (1 << CFG_IDX_W); k++) begin
      cfg_write(CFG_IDX_W'(k), CFG_DATA_W'({$urandom, $urandom}));
    end

    // Directed: saturated rates so a full-length tick always fires
    cfg_write(REG_RESTART_SEED, '0);
    cfg_write(REG_FIRST_RATE, RATE_MAX);
    cfg_write(REG_SECOND_RATE, RATE_MAX);
    cfg_write(REG_THIRD_RATE, RATE_MAX);
    cfg_write(REG_MIN_GAP_MS, CFG_DATA_W'(32'hFFFF_FFFF));
    // first channel: zero elapsed, fire, ineligible, gap hold, wrap in time
    send_tick(make_tick(OP_FIRST, '0, 1'b1, '0));
    send_tick(make_tick(OP_FIRST, MAX_MS, 1'b1, '0));
    send_tick(make_tick(OP_FIRST, MAX_MS, 1'b0, 48'd5));
    send_tick(make_tick(OP_FIRST, MAX_MS, 1'b1, 48'd100));
    send_tick(make_tick(OP_FIRST, MAX_MS, 1'b1, TOP_MS));
    send_tick(make_tick(OP_FIRST, MAX_MS, 1'b1, '0));
    // session channels: arm, fire, stay quiet, re-arm on drop, fire again
    send_tick(make_tick(OP_SECOND, MAX_MS, 1'b0, '0));
    send_tick(make_tick(OP_SECOND, MAX_MS, 1'b1, '0));
    send_tick(make_tick(OP_SECOND, MAX_MS, 1'b1, '0));
    send_tick(make_tick(OP_SECOND, MAX_MS, 1'b0, '0));
    send_tick(make_tick(OP_SECOND, MAX_MS, 1'b1, '0));
    send_tick(make_tick(OP_THIRD, MAX_MS, 1'b0, TOP_MS));
    send_tick(make_tick(OP_THIRD, MAX_MS, 1'b1, TOP_MS));
    send_tick(make_tick(OP_THIRD, MAX_MS, 1'b1, TOP_MS));
    send_tick(make_tick(OP_THIRD, MAX_MS, 1'b0, TOP_MS));
    send_tick(make_tick(OP_THIRD, MAX_MS, 1'b1, TOP_MS));
    // restart with a zero seed, then a fresh rise on each session channel
    send_tick(make_tick(OP_RESTART, MAX_MS, 1'b1, TOP_MS));
    send_tick(make_tick(OP_SECOND, MAX_MS, 1'b1, '0));
    send_tick(make_tick(OP_THIRD, '0, 1'b1, '0));
    send_tick(make_tick(OP_THIRD, MAX_MS, 1'b1, '0));
    send_tick(make_tick(OP_FIRST, MAX_MS, 1'b1, 48'd7));
    send_tick(make_tick(OP_RESTART, '0, 1'b0, '0));
    settle();

    // Random phases, extremes among them
    run_phase($urandom, any_rate(), any_rate(), any_rate(), $urandom_range(0, 3000), 280);
    run_phase('0, '0, '0, '0, '0, 130);
    run_phase(32'hFFFF_FFFF, RATE_MAX, RATE_MAX, RATE_MAX, '0, 280);
    run_phase($urandom, any_rate(), any_rate(), any_rate(), 32'hFFFF_FFFF, 280);
    run_phase($urandom, any_rate(), any_rate(), any_rate(), $urandom_range(0, 3000), 280);
    run_phase($urandom, any_rate(), any_rate(), any_rate(), $urandom_range(0, 800), 280);

    if (tracker.errors == 0) begin
      $display("tb_random_rare_event_trigger_core: clean");
    end else begin
      $display("tb_random_rare_event_trigger_core: errors");
    end
    $finish;
  end

endmodule
